// File: hdl/bounded_positional_sorted_list_unit_macros.svh
// Assertion macros used by the checker file of the sorted list unit.
`ifndef BOUNDED_POSITIONAL_SORTED_LIST_UNIT_MACROS_SVH
`define BOUNDED_POSITIONAL_SORTED_LIST_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BPSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BPSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bpsl_pkg.sv
// Types, constants and codes of the bounded positional sorted list unit.
package bpsl_pkg;

  // Default number of list cells.
  localparam int CAPACITY_DEF = 32;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 10;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 11;
  localparam int IN_DW   = 48;
  localparam int OUT_DW  = 48;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SORTED  = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_POS = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

  // Value returned by a remove at a bad position.
  localparam logic [VAL_W-1:0] VAL_BAD_REMOVE = '1;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;    // capture operation and compare results
    logic commit;  // update the cells and the output payload
  } ctrl_cmd_t;

endpackage

// File: hdl/bounded_positional_sorted_list_unit.sv
// Top level of the bounded positional sorted list unit.
// Keeps up to CAPACITY signed 32-bit values in order in a row of cells and answers each
// operation (sorted insert, insert at position, remove at position) with one result carrying
// the removed value, a status and the element count after the operation. The accepting edge
// captures an operation together with a parallel compare of every cell against the value; in
// the apply state, once the output slot is free, the commit edge shifts the cells at or after
// the target slot by one place for a valid insert or remove and loads the output register.
// The next operation is taken the cycle after the commit, so the unit takes no new operation
// while one is pending; a result left waiting holds the following operation in its shift
// step. No clearing pass runs after reset: cells above the count are never read.
module bounded_positional_sorted_list_unit
  import bpsl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // item_value[31:0], position[41:32], zero fill
  input  logic [OP_W-1:0]   in_tuser,   // opcode[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // result_value[31:0], element_count[42:32], zero fill
  output logic [ST_W-1:0]   out_tuser   // status[1:0]
);

  ctrl_cmd_t        cmd;
  logic [VAL_W-1:0] res_value;
  logic [ST_W-1:0]  res_status;
  logic [CNT_W-1:0] res_count;

  bpsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bpsl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_opcode   (in_tuser),
    .in_value    (in_tdata[VAL_W-1:0]),
    .in_position (in_tdata[VAL_W+POS_W-1:VAL_W]),
    .res_value   (res_value),
    .res_status  (res_status),
    .res_count   (res_count)
  );

  // Result packing.
  assign out_tdata = {{(OUT_DW-VAL_W-CNT_W){1'b0}}, res_count, res_value};
  assign out_tuser = res_status;

endmodule

// File: hdl/bpsl_ctrl.sv
// Controller of the sorted list unit: operation sequencing and output valid.
module bpsl_ctrl
  import bpsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output slot can take a new result this cycle.
  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_APPLY: begin
        cmd.commit = out_free;
      end
      default: ;
    endcase
  end

  // Output valid holds until the result transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/bpsl_dpath.sv
// Datapath of the sorted list unit: cell row, count, compares and result payload.
module bpsl_dpath
  import bpsl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  input  logic [OP_W-1:0]  in_opcode,
  input  logic [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0] in_position,
  output logic [VAL_W-1:0] res_value,
  output logic [ST_W-1:0]  res_status,
  output logic [CNT_W-1:0] res_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int LV = $clog2(CAPACITY);

  // Cell row and count.
  logic [VAL_W-1:0] cell_r   [CAPACITY];
  logic [VAL_W-1:0] cell_nxt [CAPACITY];
  logic [CW-1:0]    count_r, count_nxt;

  // Captured operation.
  logic [OP_W-1:0]     op_r;
  logic [VAL_W-1:0]    val_r;
  logic [POS_W-1:0]    pos_r;
  logic [CAPACITY-1:0] ge_r, ge_nxt;

  // Result payload.
  logic [VAL_W-1:0] res_r, res_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;

  // Apply-stage decode.
  logic                write_en;
  logic                is_remove;
  logic [CAPACITY-1:0] after;
  logic                full;
  logic [VAL_W-1:0]    rd_value;

  // Per-cell compare against the incoming value; the slot at the count always qualifies.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_nxt[i] = ((CW'(i) < count_r) && ($signed(cell_r[i]) >= $signed(in_value)))
                  || (CW'(i) == count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      val_r <= in_value;
      pos_r <= in_position;
      ge_r  <= ge_nxt;
    end
  end

  assign full     = (count_r == CW'(CAPACITY));
  assign rd_value = cell_r[pos_r[IW-1:0]];

  // Status, result and write decision.
  always_comb begin
    res_nxt   = '0;
    st_nxt    = ST_DONE;
    write_en  = 1'b0;
    is_remove = 1'b0;
    unique case (op_r)
      OP_SORTED: begin
        if (full) st_nxt = ST_FULL;
        else write_en = 1'b1;
      end
      OP_INS_POS: begin
        if (CNT_W'(pos_r) > CNT_W'(count_r)) st_nxt = ST_INVALID;
        else if (full) st_nxt = ST_FULL;
        else write_en = 1'b1;
      end
      OP_REMOVE: begin
        is_remove = 1'b1;
        if (CNT_W'(pos_r) >= CNT_W'(count_r)) begin
          st_nxt  = ST_INVALID;
          res_nxt = VAL_BAD_REMOVE;
        end else begin
          write_en = 1'b1;
          res_nxt  = rd_value;
        end
      end
      default: st_nxt = ST_INVALID;
    endcase
  end

  // Cells at or after the target slot: prefix OR of the compares, or a position compare.
  always_comb begin
    logic [CAPACITY-1:0] p;
    p = ge_r;
    for (int k = 0; k < LV; k++) begin
      p = p | (p << (1 << k));
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (op_r == OP_SORTED) after[i] = p[i];
      else after[i] = (POS_W'(i) >= pos_r);
    end
  end

  // Shift the row open for an insert or closed for a remove.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (is_remove) begin
        if (after[i] && (i < CAPACITY - 1)) cell_nxt[i] = cell_r[(i + 1) % CAPACITY];
      end else if ((i > 0) && after[(i + CAPACITY - 1) % CAPACITY]) begin
        cell_nxt[i] = cell_r[(i + CAPACITY - 1) % CAPACITY];
      end else if (after[i]) begin
        cell_nxt[i] = val_r;
      end
    end
  end

  // Count update.
  always_comb begin
    count_nxt = count_r;
    if (write_en) begin
      if (is_remove) count_nxt = count_r - CW'(1);
      else count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && write_en) begin
      for (int i = 0; i < CAPACITY; i++) cell_r[i] <= cell_nxt[i];
    end
    if (cmd.commit) begin
      res_r <= res_nxt;
      st_r  <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Count changes only on a commit, which waits for the previous result transfer.
  assign res_value  = res_r;
  assign res_status = st_r;
  assign res_count  = CNT_W'(count_r);

endmodule

// File: hdl/bpsl_checker.sv
// Port-level checker of the sorted list unit and its bind to the top level.
`include "bounded_positional_sorted_list_unit_macros.svh"

module bpsl_checker
  import bpsl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [ST_W-1:0]   out_tuser
);

  // A stalled result stays offered.
  `BPSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // One operation at a time: no second transfer right after one.
  `BPSL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // The count never exceeds the capacity.
  `BPSL_ASSERT_NOW(a_count_bound, clk, rst_n, out_tvalid, out_tdata[VAL_W+CNT_W-1:VAL_W] <= CNT_W'(CAPACITY), "count above capacity")

  // A full status only comes with a full list.
  `BPSL_ASSERT_NOW(a_full_count, clk, rst_n, out_tvalid && (out_tuser == ST_FULL), out_tdata[VAL_W+CNT_W-1:VAL_W] == CNT_W'(CAPACITY), "full status with room left")

endmodule

bind bounded_positional_sorted_list_unit bpsl_checker #(.CAPACITY(CAPACITY)) u_bpsl_checker (.*);
